// ===== hw/rtl/euler_zyx_rotation_matrix_defines.svh =====
// Assertion macros used by the rotation matrix top module.
`ifndef EULER_ZYX_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ZYX_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define EZYX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define EZYX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EZYX_ASSERT_IMPL(lbl, ante, cons)
`define EZYX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ezyx_pkg.sv =====
// Types, constants and helper functions of the rotation matrix block.
package ezyx_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COEF_BITS = 16;
  localparam int ANG_FRAC = ANGLE_BITS - 3;
  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam int Z_FRAC = 16;
  localparam int XY_FRAC = 30;
  localparam int ITERS = 16;
  localparam int ITERS_PER_STAGE = 4;
  localparam int CORDIC_STAGES = ITERS / ITERS_PER_STAGE;
  localparam int ZW = 21;
  localparam int XYW = 34;
  localparam int PW = 2 * COEF_BITS;
  // Register stages from request acceptance to result register.
  localparam int LAT = CORDIC_STAGES + 6;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [ZW-1:0] z_t;
  typedef logic signed [XYW-1:0] xy_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [PW:0] sum_t;

  localparam z_t PI_Z = ZW'(205887);
  localparam z_t HALF_PI_Z = ZW'(102944);
  localparam z_t TWO_PI_Z = ZW'(411774);
  localparam xy_t GAIN = XYW'(652032874);
  localparam coef_t ONE = COEF_BITS'(1 << COEF_FRAC);

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic z_t atan_z(input int i);
    z_t r;
    case (i)
      0: r = ZW'(51472);
      1: r = ZW'(30385);
      2: r = ZW'(16055);
      3: r = ZW'(8150);
      4: r = ZW'(4091);
      5: r = ZW'(2047);
      6: r = ZW'(1024);
      7: r = ZW'(512);
      8: r = ZW'(256);
      9: r = ZW'(128);
      10: r = ZW'(64);
      11: r = ZW'(32);
      12: r = ZW'(16);
      13: r = ZW'(8);
      14: r = ZW'(4);
      15: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round a product sum half up to the coefficient format and clamp to +-1.0.
  function automatic coef_t rnd_sat(input sum_t v);
    sum_t r;
    coef_t o;
    r = (v + sum_t'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (r > sum_t'(ONE)) begin
      o = ONE;
    end else if (r < -sum_t'(ONE)) begin
      o = -ONE;
    end else begin
      o = COEF_BITS'(r);
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/ezyx_in_if.sv =====
// Request channel carrying the three rotation angles.
interface ezyx_in_if;
  logic valid;
  logic ready;
  ezyx_pkg::angle_t angle_x;
  ezyx_pkg::angle_t angle_y;
  ezyx_pkg::angle_t angle_z;
  modport source(output valid, angle_x, angle_y, angle_z, input ready);
  modport sink(input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// ===== hw/rtl/ezyx_out_if.sv =====
// Result channel carrying the nine matrix entries.
interface ezyx_out_if;
  logic valid;
  logic ready;
  ezyx_pkg::coef_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               output ready);
endinterface

// ===== hw/rtl/ezyx_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine of one angle.
module ezyx_cordic (
  input  logic             clk,
  input  logic             en,
  input  ezyx_pkg::angle_t angle,
  output ezyx_pkg::coef_t  cosine,
  output ezyx_pkg::coef_t  sine
);
  localparam int SHL = (ezyx_pkg::ANG_FRAC > ezyx_pkg::Z_FRAC) ? 0 :
                       ezyx_pkg::Z_FRAC - ezyx_pkg::ANG_FRAC;
  localparam int SHR = (ezyx_pkg::ANG_FRAC > ezyx_pkg::Z_FRAC) ?
                       ezyx_pkg::ANG_FRAC - ezyx_pkg::Z_FRAC : 0;
  localparam int EW = ezyx_pkg::ANGLE_BITS + SHL + 1;
  localparam int XSHR = ezyx_pkg::XY_FRAC - ezyx_pkg::COEF_FRAC;
  localparam int RW = ezyx_pkg::XYW + 1;

  ezyx_pkg::xy_t s_x [0:ezyx_pkg::CORDIC_STAGES];
  ezyx_pkg::xy_t s_y [0:ezyx_pkg::CORDIC_STAGES];
  ezyx_pkg::z_t  s_z [0:ezyx_pkg::CORDIC_STAGES];
  logic          s_neg [0:ezyx_pkg::CORDIC_STAGES];

  logic signed [EW-1:0] ze;
  ezyx_pkg::z_t z0, zr, zf;
  logic neg0;

  // Convert to the internal angle unit, wrap into +-pi and fold into +-pi/2.
  always_comb begin
    ze = (($signed({{(SHL + 1){angle[ezyx_pkg::ANGLE_BITS-1]}}, angle}) <<< SHL)
          + EW'((1 << SHR) >> 1)) >>> SHR;
    z0 = ezyx_pkg::ZW'(ze);
    if (z0 > ezyx_pkg::PI_Z) begin
      zr = z0 - ezyx_pkg::TWO_PI_Z;
    end else if (z0 < -ezyx_pkg::PI_Z) begin
      zr = z0 + ezyx_pkg::TWO_PI_Z;
    end else begin
      zr = z0;
    end
    neg0 = 1'b0;
    zf = zr;
    if (zr > ezyx_pkg::HALF_PI_Z) begin
      zf = zr - ezyx_pkg::PI_Z;
      neg0 = 1'b1;
    end else if (zr < -ezyx_pkg::HALF_PI_Z) begin
      zf = zr + ezyx_pkg::PI_Z;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_x[0] <= ezyx_pkg::GAIN;
      s_y[0] <= '0;
      s_z[0] <= zf;
      s_neg[0] <= neg0;
    end
  end

  // Each stage performs a fixed group of micro-rotations.
  for (genvar k = 0; k < ezyx_pkg::CORDIC_STAGES; k++) begin : g_stage
    ezyx_pkg::xy_t x_n, y_n;
    ezyx_pkg::z_t z_n;

    always_comb begin : p_iter
      ezyx_pkg::xy_t dx, dy;
      x_n = s_x[k];
      y_n = s_y[k];
      z_n = s_z[k];
      for (int j = 0; j < ezyx_pkg::ITERS_PER_STAGE; j++) begin
        dx = y_n >>> (k * ezyx_pkg::ITERS_PER_STAGE + j);
        dy = x_n >>> (k * ezyx_pkg::ITERS_PER_STAGE + j);
        if (z_n >= 0) begin
          x_n = x_n - dx;
          y_n = y_n + dy;
          z_n = z_n - ezyx_pkg::atan_z(k * ezyx_pkg::ITERS_PER_STAGE + j);
        end else begin
          x_n = x_n + dx;
          y_n = y_n - dy;
          z_n = z_n + ezyx_pkg::atan_z(k * ezyx_pkg::ITERS_PER_STAGE + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_x[k+1] <= x_n;
        s_y[k+1] <= y_n;
        s_z[k+1] <= z_n;
        s_neg[k+1] <= s_neg[k];
      end
    end
  end

  localparam int LS = ezyx_pkg::CORDIC_STAGES;
  logic signed [RW-1:0] xr, yr, one_w;
  ezyx_pkg::coef_t cos_next, sin_next;

  // Undo the fold, round to the coefficient format and clamp to +-1.0.
  always_comb begin
    one_w = RW'(ezyx_pkg::ONE);
    xr = ((s_neg[LS] ? -RW'(s_x[LS]) : RW'(s_x[LS])) + RW'((1 << XSHR) >> 1))
         >>> XSHR;
    yr = ((s_neg[LS] ? -RW'(s_y[LS]) : RW'(s_y[LS])) + RW'((1 << XSHR) >> 1))
         >>> XSHR;
    if (xr > one_w) begin
      cos_next = ezyx_pkg::ONE;
    end else if (xr < -one_w) begin
      cos_next = -ezyx_pkg::ONE;
    end else begin
      cos_next = ezyx_pkg::COEF_BITS'(xr);
    end
    if (yr > one_w) begin
      sin_next = ezyx_pkg::ONE;
    end else if (yr < -one_w) begin
      sin_next = -ezyx_pkg::ONE;
    end else begin
      sin_next = ezyx_pkg::COEF_BITS'(yr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosine <= cos_next;
      sine <= sin_next;
    end
  end

endmodule

// ===== hw/rtl/euler_zyx_rotation_matrix.sv =====
// ZYX Euler-angle rotation matrix Rz*Ry*Rx, fully pipelined.
//
//   channel | dir | payload
//   --------+-----+--------------------------------------
//   ang     | in  | angle_x, angle_y, angle_z (Q3.13 rad)
//   mat     | out | m00 .. m22 (Q2.14, clamped to +-1.0)
//
// One request enters every cycle unless the pipeline stalls; each result passes
// 6 CORDIC stages (fold, 4 x 4 iterations, round) and then 4 matrix stages.
// A single enable advances the whole pipeline; it drops only while the result
// register holds a result that the sink has not taken, so nothing is lost.
// Synchronous reset clears the valid bits only.
`include "euler_zyx_rotation_matrix_defines.svh"
module euler_zyx_rotation_matrix (
  input logic      clk,
  input logic      rst,
  ezyx_in_if.sink  ang,
  ezyx_out_if.source mat
);
  logic [ezyx_pkg::LAT-1:0] v;
  logic en;

  ezyx_pkg::coef_t cx, sx, cy, sy, cz, sz;

  assign en = !v[ezyx_pkg::LAT-1] || mat.ready;
  assign ang.ready = en;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ezyx_pkg::LAT-2:0], ang.valid};
    end
  end

  ezyx_cordic u_cx (.clk(clk), .en(en), .angle(ang.angle_x), .cosine(cx), .sine(sx));
  ezyx_cordic u_cy (.clk(clk), .en(en), .angle(ang.angle_y), .cosine(cy), .sine(sy));
  ezyx_cordic u_cz (.clk(clk), .en(en), .angle(ang.angle_z), .cosine(cz), .sine(sz));

  // First product stage: the four nontrivial products of Rz*Ry.
  ezyx_pkg::prod_t p_czcy, p_czsy, p_szcy, p_szsy;
  ezyx_pkg::coef_t a_cz, a_sz, a_cy, a_sy, a_cx, a_sx;

  always_ff @(posedge clk) begin
    if (en) begin
      p_czcy <= cz * cy;
      p_czsy <= cz * sy;
      p_szcy <= sz * cy;
      p_szsy <= sz * sy;
      a_cz <= cz;
      a_sz <= sz;
      a_cy <= cy;
      a_sy <= sy;
      a_cx <= cx;
      a_sx <= sx;
    end
  end

  // Rounded intermediate matrix T = Rz*Ry.
  ezyx_pkg::coef_t t [0:2][0:2];
  ezyx_pkg::coef_t b_cx, b_sx;

  always_ff @(posedge clk) begin
    if (en) begin
      t[0][0] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(p_czcy));
      t[0][1] <= -a_sz;
      t[0][2] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(p_czsy));
      t[1][0] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(p_szcy));
      t[1][1] <= a_cz;
      t[1][2] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(p_szsy));
      t[2][0] <= -a_sy;
      t[2][1] <= '0;
      t[2][2] <= a_cy;
      b_cx <= a_cx;
      b_sx <= a_sx;
    end
  end

  // Second product stage: columns 1 and 2 of T*Rx.
  ezyx_pkg::prod_t q [0:2][0:3];
  ezyx_pkg::coef_t c0 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q[i][0] <= t[i][1] * b_cx;
        q[i][1] <= t[i][2] * b_sx;
        q[i][2] <= t[i][1] * b_sx;
        q[i][3] <= t[i][2] * b_cx;
        c0[i] <= t[i][0];
      end
    end
  end

  // Result register: sum, round and clamp columns 1 and 2; column 0 passes through.
  ezyx_pkg::coef_t r [0:2][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r[i][0] <= c0[i];
        r[i][1] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(q[i][0]) +
                                     ezyx_pkg::sum_t'(q[i][1]));
        r[i][2] <= ezyx_pkg::rnd_sat(ezyx_pkg::sum_t'(q[i][3]) -
                                     ezyx_pkg::sum_t'(q[i][2]));
      end
    end
  end

  assign mat.valid = v[ezyx_pkg::LAT-1];
  assign mat.m00 = r[0][0];
  assign mat.m01 = r[0][1];
  assign mat.m02 = r[0][2];
  assign mat.m10 = r[1][0];
  assign mat.m11 = r[1][1];
  assign mat.m12 = r[1][2];
  assign mat.m20 = r[2][0];
  assign mat.m21 = r[2][1];
  assign mat.m22 = r[2][2];

  // An accepted request occupies the first pipeline slot.
  `EZYX_ASSERT_NEXT(a_enter, ang.valid && ang.ready, v[0])
  // A stall freezes every valid bit.
  `EZYX_ASSERT_NEXT(a_hold, !en, v == $past(v))
  // Delivered entries m01 and m22 stay within +-1.0.
  `EZYX_ASSERT_IMPL(a_m01_range, mat.valid,
                    mat.m01 <= ezyx_pkg::ONE && mat.m01 >= -ezyx_pkg::ONE)
  `EZYX_ASSERT_IMPL(a_m22_range, mat.valid,
                    mat.m22 <= ezyx_pkg::ONE && mat.m22 >= -ezyx_pkg::ONE)

endmodule
